// File: design/sbt_pkg.sv
// Shared widths, codes and types of the sorted symbol binding table.
`timescale 1ns / 1ps

package sbt_pkg;

    // Field widths of the request and response items
    localparam int FUNC_W        = 2;
    localparam int KEY_W         = 32;
    localparam int VALUE_W       = 64;
    localparam int STATUS_W      = 2;
    localparam int POSITION_W    = 6;
    localparam int ENTRY_COUNT_W = 7;

    // Default sizing of the table
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;

    // Request function codes; the unused code behaves as a find
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPSERT = 2'd2;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_EXISTED   = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Update applied to the cell row at the end of a request
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [VALUE_W-1:0]    value;
    } cell_cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_CMP    = 2'd1,
        S_TREE   = 2'd2,
        S_DECIDE = 2'd3
    } fsm_state_t;

endpackage

// File: design/sbt_ifs.sv
// Valid/ready channel interfaces of the sorted symbol binding table.
`timescale 1ns / 1ps

interface sbt_req_if;
    logic                         valid;
    logic                         ready;
    logic [sbt_pkg::FUNC_W-1:0]   func;
    logic [sbt_pkg::KEY_W-1:0]    key;
    logic [sbt_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface sbt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [sbt_pkg::STATUS_W-1:0]       status;
    logic [sbt_pkg::VALUE_W-1:0]        bound_value;
    logic [sbt_pkg::POSITION_W-1:0]     position;
    logic [sbt_pkg::ENTRY_COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output bound_value, output position,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input bound_value, input position,
                    input entry_count, output ready);
endinterface

interface sbt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [sbt_pkg::VALUE_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/sbt_cell.sv
// One cell of the sorted row: holds one binding and shifts with its left neighbor.
`timescale 1ns / 1ps

module sbt_cell #(
    parameter int CMP_BITS = 32,
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                          clk,
    input  logic                          cmp_en,
    input  logic [CMP_BITS-1:0]           req_key,
    input  logic [CNT_W-1:0]              count,
    input  sbt_pkg::cell_cmd_t            cmd,
    input  logic [CMP_BITS-1:0]           left_key,
    input  logic [sbt_pkg::VALUE_W-1:0]   left_value,
    input  logic                          left_lt,
    output logic [CMP_BITS-1:0]           key,
    output logic [sbt_pkg::VALUE_W-1:0]   value,
    output logic                          lt,
    output logic                          hit,
    output logic                          found
);
    import sbt_pkg::*;

    logic [CMP_BITS-1:0] key_reg;
    logic [CMP_BITS-1:0] key_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [VALUE_W-1:0]  value_next;
    logic                lt_reg;
    logic                eq_reg;
    logic                occupied;
    logic                at_pos;

    // Entries at or above the count take no part in the search
    assign occupied = (CNT_W'(CELL_IDX) < count);

    // Capture the compare against the request key
    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            lt_reg <= occupied && (key_reg < req_key);
            eq_reg <= occupied && (key_reg == req_key);
        end
    end

    // The lower bound sits where the "less than" prefix ends
    assign at_pos = !lt_reg && left_lt;

    // Rebind, insert here, or take the left neighbor's entry
    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        case (cmd.op)
            OP_WRITE:
            begin
                if (at_pos)
                begin
                    value_next = cmd.value;
                end
            end
            OP_INSERT:
            begin
                if (at_pos)
                begin
                    key_next   = req_key;
                    value_next = cmd.value;
                end
                else if (!left_lt)
                begin
                    key_next   = left_key;
                    value_next = left_value;
                end
            end
            default:
            begin
                key_next   = key_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign lt    = lt_reg;
    assign hit   = at_pos;
    assign found = at_pos && eq_reg;

endmodule

// File: design/sbt_or_tree.sv
// Registered OR-reduction tree that collects the payload of the one hit cell.
`timescale 1ns / 1ps

module sbt_or_tree #(
    parameter int LEAVES = 64,
    parameter int W      = 72
) (
    input  logic          clk,
    input  logic [W-1:0]  leaf [LEAVES],
    output logic [W-1:0]  root
);
    import sbt_pkg::*;

    localparam int LEVELS = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int N      = 1 << LEVELS;

    logic [W-1:0] leaf_w   [N];
    logic [W-1:0] node_reg [N-1];

    // Pad the leaf row to a power of two with zeros
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_leaf
            if (gi < LEAVES)
            begin : g_real
                assign leaf_w[gi] = leaf[gi];
            end
            else
            begin : g_pad
                assign leaf_w[gi] = '0;
            end
        end

        // Heap-ordered nodes, one register level per tree level
        for (gi = 0; gi < N - 1; gi++)
        begin : g_node
            if (2 * gi + 1 >= N - 1)
            begin : g_bottom
                always_ff @(posedge clk)
                begin
                    node_reg[gi] <= leaf_w[2 * gi + 1 - (N - 1)]
                                  | leaf_w[2 * gi + 2 - (N - 1)];
                end
            end
            else
            begin : g_inner
                always_ff @(posedge clk)
                begin
                    node_reg[gi] <= node_reg[2 * gi + 1] | node_reg[2 * gi + 2];
                end
            end
        end
    endgenerate

    assign root = node_reg[0];

endmodule

// File: design/sorted_symbol_binding_table.sv
// Sorted symbol binding table: a row of cells kept in ascending key order.
// Each request is taken only while the block is idle. It then passes through a
// compare step in which every cell compares its key with the request key, the
// registered OR tree, one register level per tree level, that brings the
// lower-bound cell's value, position and match flag to the sequencer, and a
// decide step that updates the row and loads the response register. The block
// returns to idle as the response is loaded, so it takes no new request before
// it is through with the last one. An insertion moves every larger entry up one
// cell at once, each cell taking its left neighbor's binding. The response sits
// in an output register, so the next request is accepted while a response still
// waits to be taken; the decide step stalls until that register frees up. Keys
// are compared on their low min(KEY_BITS, 32) bits. The nil word register may be
// written at any time the block is idle and is always ready.
`timescale 1ns / 1ps

module sorted_symbol_binding_table #(
    parameter int TABLE_DEPTH = sbt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = sbt_pkg::KEY_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    sbt_cfg_if.sink   cfg,
    sbt_req_if.sink   req,
    sbt_rsp_if.source rsp
);
    import sbt_pkg::*;

    localparam int CMP_BITS  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int LEVELS    = $clog2(TABLE_DEPTH);
    localparam int LVL_CNT_W = $clog2(LEVELS + 1);
    localparam int LEAF_W    = 1 + VALUE_W + IDX_W;

    fsm_state_t              state_reg;
    fsm_state_t              state_next;
    logic [LVL_CNT_W-1:0]    lvl_cnt_reg;
    logic [LVL_CNT_W-1:0]    lvl_cnt_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [VALUE_W-1:0]      nil_reg;
    logic [FUNC_W-1:0]       func_reg;
    logic [CMP_BITS-1:0]     key_reg;
    logic [VALUE_W-1:0]      value_reg;

    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    status_t                 status_reg;
    logic [VALUE_W-1:0]      bound_reg;
    logic [POSITION_W-1:0]   position_reg;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;

    logic                    cmp_en;
    logic                    out_free;
    logic                    commit;
    cell_cmd_t               cmd;
    cell_cmd_t               dec_cmd;
    status_t                 dec_status;
    logic [VALUE_W-1:0]      dec_bound;
    logic [IDX_W-1:0]        dec_pos;
    logic [CNT_W-1:0]        dec_count;

    logic [CMP_BITS-1:0]     cell_key   [TABLE_DEPTH];
    logic [VALUE_W-1:0]      cell_value [TABLE_DEPTH];
    logic                    cell_lt    [TABLE_DEPTH];
    logic                    cell_hit   [TABLE_DEPTH];
    logic                    cell_found [TABLE_DEPTH];
    logic [LEAF_W-1:0]       leaf       [TABLE_DEPTH];
    logic [LEAF_W-1:0]       root;

    logic                    root_found;
    logic [VALUE_W-1:0]      root_value;
    logic [IDX_W-1:0]        root_idx;
    logic                    is_insert;
    logic                    is_full;

    // Configuration: the nil word register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nil_reg <= '0;
        end
        else if (cfg.valid)
        begin
            nil_reg <= cfg.data;
        end
    end

    // Latch the request on transfer
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg  <= req.func;
            key_reg   <= req.key[CMP_BITS-1:0];
            value_reg <= req.value;
        end
    end

    // Row of cells, each fed by its left neighbor
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic [CMP_BITS-1:0] lkey;
            logic [VALUE_W-1:0]  lvalue;
            logic                llt;

            if (gi == 0)
            begin : g_first
                assign lkey   = '0;
                assign lvalue = '0;
                assign llt    = 1'b1;
            end
            else
            begin : g_next
                assign lkey   = cell_key[gi-1];
                assign lvalue = cell_value[gi-1];
                assign llt    = cell_lt[gi-1];
            end

            sbt_cell #(
                .CMP_BITS (CMP_BITS),
                .CNT_W    (CNT_W),
                .CELL_IDX (gi)
            ) u_cell (
                .clk        (clk),
                .cmp_en     (cmp_en),
                .req_key    (key_reg),
                .count      (count_reg),
                .cmd        (cmd),
                .left_key   (lkey),
                .left_value (lvalue),
                .left_lt    (llt),
                .key        (cell_key[gi]),
                .value      (cell_value[gi]),
                .lt         (cell_lt[gi]),
                .hit        (cell_hit[gi]),
                .found      (cell_found[gi])
            );

            // Only the lower-bound cell drives a nonzero leaf
            assign leaf[gi] = cell_hit[gi]
                            ? {cell_found[gi], cell_value[gi], IDX_W'(gi)}
                            : '0;
        end
    endgenerate

    sbt_or_tree #(
        .LEAVES (TABLE_DEPTH),
        .W      (LEAF_W)
    ) u_tree (
        .clk  (clk),
        .leaf (leaf),
        .root (root)
    );

    assign root_found = root[LEAF_W-1];
    assign root_value = root[IDX_W +: VALUE_W];
    assign root_idx   = root[IDX_W-1:0];

    // Decide the outcome from the tree result
    assign is_insert = (func_reg == FUNC_INSERT) || (func_reg == FUNC_UPSERT);
    assign is_full   = (count_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        dec_cmd.op    = OP_NONE;
        dec_cmd.value = value_reg;
        dec_status    = ST_NOT_FOUND;
        dec_bound     = '0;
        dec_pos       = '0;
        dec_count     = count_reg;
        if (root_found)
        begin
            dec_status = ST_EXISTED;
            dec_pos    = root_idx;
            if (func_reg == FUNC_UPSERT)
            begin
                dec_cmd.op = OP_WRITE;
                dec_bound  = value_reg;
            end
            else
            begin
                dec_bound  = root_value;
            end
        end
        else if (is_insert)
        begin
            if (is_full)
            begin
                dec_status = ST_FULL;
            end
            else
            begin
                dec_status    = ST_INSERTED;
                dec_cmd.op    = OP_INSERT;
                dec_cmd.value = (func_reg == FUNC_INSERT) ? nil_reg : value_reg;
                dec_bound     = dec_cmd.value;
                dec_pos       = root_idx;
                dec_count     = count_reg + CNT_W'(1);
            end
        end
    end

    assign out_free = !rsp_valid_reg || rsp.ready;

    // Sequencer: next state
    always_comb
    begin
        state_next   = state_reg;
        lvl_cnt_next = lvl_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next   = S_TREE;
                lvl_cnt_next = '0;
            end
            S_TREE:
            begin
                if (lvl_cnt_reg == LVL_CNT_W'(LEVELS - 1))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    lvl_cnt_next = lvl_cnt_reg + LVL_CNT_W'(1);
                end
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        req.ready = 1'b0;
        cmp_en    = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            S_IDLE:   req.ready = 1'b1;
            S_CMP:    cmp_en    = 1'b1;
            S_DECIDE: commit    = out_free;
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cmd.op    = commit ? dec_cmd.op : OP_NONE;
        cmd.value = dec_cmd.value;
    end

    assign count_next = commit ? dec_count : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lvl_cnt_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            lvl_cnt_reg <= lvl_cnt_next;
            count_reg   <= count_next;
        end
    end

    // Response register: load on commit, drop on transfer
    assign rsp_valid_next = commit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg      <= dec_status;
            bound_reg       <= dec_bound;
            position_reg    <= POSITION_W'(dec_pos);
            entry_count_reg <= ENTRY_COUNT_W'(dec_count);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.bound_value = bound_reg;
    assign rsp.position    = position_reg;
    assign rsp.entry_count = entry_count_reg;

endmodule

// File: design/sbt_checker.sv
// Port-level assertions for the sorted symbol binding table, bound to the top level.
`timescale 1ns / 1ps

module sbt_checker #(
    parameter int TABLE_DEPTH = sbt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  logic                               req_ready,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  logic [sbt_pkg::STATUS_W-1:0]       rsp_status,
    input  logic [sbt_pkg::VALUE_W-1:0]        rsp_bound_value,
    input  logic [sbt_pkg::POSITION_W-1:0]     rsp_position,
    input  logic [sbt_pkg::ENTRY_COUNT_W-1:0]  rsp_entry_count
);
    import sbt_pkg::*;

    // Hold a stalled response unchanged
    property p_rsp_hold;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_bound_value) && $stable(rsp_position)
            && $stable(rsp_entry_count);
    endproperty
    a_rsp_hold: assert property (p_rsp_hold)
        else $error("stalled response changed");

    // One request in flight: ready drops after a transfer
    property p_one_in_flight;
        @(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready;
    endproperty
    a_one_in_flight: assert property (p_one_in_flight)
        else $error("request accepted on consecutive cycles");

    // A full report means the table holds every entry
    property p_full_count;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL)
            |-> rsp_entry_count == ENTRY_COUNT_W'(TABLE_DEPTH);
    endproperty
    a_full_count: assert property (p_full_count)
        else $error("table full reported below capacity");

    // Misses and full reports carry no binding
    property p_miss_zero;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == ST_NOT_FOUND) || (rsp_status == ST_FULL))
            |-> (rsp_bound_value == '0) && (rsp_position == '0);
    endproperty
    a_miss_zero: assert property (p_miss_zero)
        else $error("miss response carries a binding");

    // A fresh insertion leaves at least one entry
    property p_insert_count;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_INSERTED) |-> rsp_entry_count != '0;
    endproperty
    a_insert_count: assert property (p_insert_count)
        else $error("insertion reported with an empty table");

endmodule

bind sorted_symbol_binding_table sbt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sbt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_bound_value (rsp.bound_value),
    .rsp_position    (rsp.position),
    .rsp_entry_count (rsp.entry_count)
);

// File: dv/sbt_binding_checker.sv
// Checker for the sorted symbol binding table: tracks the bindings, predicts and compares.
`timescale 1ns / 1ps

module sbt_binding_checker
    import sbt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sbt_cfg_if   cfg,
    sbt_req_if   req,
    sbt_rsp_if   rsp,
    output int   errors,
    output int   pending,
    output int   n_existed,
    output int   n_inserted,
    output int   n_not_found,
    output int   n_full
);

    localparam int DEPTH = TABLE_DEPTH_DEF;

    typedef struct packed {
        status_t                   status;
        logic [VALUE_W-1:0]        bound;
        logic [POSITION_W-1:0]     pos;
        logic [ENTRY_COUNT_W-1:0]  cnt;
    } binding_rsp_t;

    // Shadow copy of the table and its nil word
    logic [KEY_W-1:0]   key_tab [DEPTH];
    logic [VALUE_W-1:0] val_tab [DEPTH];
    int                 entries;
    logic [VALUE_W-1:0] nil_word;

    binding_rsp_t       binding_q [$];

    // Apply one request to the shadow table and return the response it must produce
    function automatic binding_rsp_t resolve_request(logic [FUNC_W-1:0] f,
                                                     logic [KEY_W-1:0] k,
                                                     logic [VALUE_W-1:0] v);
        binding_rsp_t r;
        int           slot;
        bit           hit;
        r    = '0;
        slot = 0;
        // first slot whose key is not below k
        while (slot < entries && key_tab[slot] < k)
            slot++;
        hit = (slot < entries) && (key_tab[slot] == k);
        if (hit)
        begin
            if (f == FUNC_UPSERT)
                val_tab[slot] = v;
            r.status = ST_EXISTED;
            r.bound  = val_tab[slot];
            r.pos    = POSITION_W'(slot);
        end
        else if (f == FUNC_INSERT || f == FUNC_UPSERT)
        begin
            if (entries >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                // open a hole at slot by moving larger keys up
                for (int i = entries; i > slot; i--)
                begin
                    key_tab[i] = key_tab[i-1];
                    val_tab[i] = val_tab[i-1];
                end
                key_tab[slot] = k;
                val_tab[slot] = (f == FUNC_INSERT) ? nil_word : v;
                entries++;
                r.status = ST_INSERTED;
                r.bound  = val_tab[slot];
                r.pos    = POSITION_W'(slot);
            end
        end
        else
            r.status = ST_NOT_FOUND;
        r.cnt = ENTRY_COUNT_W'(entries);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        binding_rsp_t want;
        binding_rsp_t got;
        if (!rst_n)
        begin
            entries     = 0;
            nil_word    = '0;
            errors      = 0;
            n_existed   = 0;
            n_inserted  = 0;
            n_not_found = 0;
            n_full      = 0;
            binding_q.delete();
            pending     = 0;
        end
        else
        begin
            // Track nil word writes
            if (cfg.valid && cfg.ready)
                nil_word = cfg.data;

            // Compare each response transfer with the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                got = {status_t'(rsp.status), rsp.bound_value, rsp.position, rsp.entry_count};
                if (binding_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: response with nothing outstanding: status %0d value %h",
                                 $realtime, got.status, got.bound);
                end
                else
                begin
                    want = binding_q.pop_front();
                    case (want.status)
                        ST_EXISTED:   n_existed++;
                        ST_INSERTED:  n_inserted++;
                        ST_NOT_FOUND: n_not_found++;
                        default:      n_full++;
                    endcase
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $write("%0t: mismatch: expected status %0d value %h pos %0d count %0d, ",
                                   $realtime, want.status, want.bound, want.pos, want.cnt);
                            $display("got status %0d value %h pos %0d count %0d",
                                     got.status, got.bound, got.pos, got.cnt);
                        end
                    end
                end
            end

            // Predict the response of each request transfer
            if (req.valid && req.ready)
                binding_q.push_back(resolve_request(req.func, req.key, req.value));

            pending = binding_q.size();
        end
    end

endmodule

// File: dv/tb_sorted_symbol_binding_table.sv
// Top of the sorted symbol binding table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_sorted_symbol_binding_table;
    import sbt_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam logic [VALUE_W-1:0] ALL_ONES  = '1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 12;
    localparam int RANDOM_BLOCK = 145;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int errors;
    int pending;
    int n_existed;
    int n_inserted;
    int n_not_found;
    int n_full;
    int cycle_count = 0;
    int sent        = 0;
    int nil_writes  = 0;
    bit req_burst   = 1'b0;
    bit rsp_burst   = 1'b0;

    logic [KEY_W-1:0] used_keys [$];

    sbt_cfg_if cfg_ch ();
    sbt_req_if req_ch ();
    sbt_rsp_if rsp_ch ();

    sorted_symbol_binding_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sbt_binding_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .errors      (errors),
        .pending     (pending),
        .n_existed   (n_existed),
        .n_inserted  (n_inserted),
        .n_not_found (n_not_found),
        .n_full      (n_full)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d responses outstanding",
                     cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // Stall the response side a random number of cycles before each transfer
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 23) == 0)
                rsp_burst = !rsp_burst;
            stall = rsp_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // Send one request after a random gap; valid stays high for a back-to-back transfer
    task automatic put_request(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                               input logic [VALUE_W-1:0] v);
        int gap;
        if ($urandom_range(0, 23) == 0)
            req_burst = !req_burst;
        gap = req_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= f;
        req_ch.key   <= k;
        req_ch.value <= v;
        do @(posedge clk); while (!req_ch.ready);
        sent++;
        if (f == FUNC_INSERT || f == FUNC_UPSERT)
            used_keys.push_back(k);
    endtask

    // Drop valid and wait until every response has come back
    task automatic drain_table();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Write the nil word once the block is idle
    task automatic set_nil_word(input logic [VALUE_W-1:0] w);
        drain_table();
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        nil_writes++;
    endtask

    // Mostly finds, inserts and updates; a few spare codes
    function automatic logic [FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return FUNC_FIND;
        else if (r < 60)
            return FUNC_INSERT;
        else if (r < 95)
            return FUNC_UPSERT;
        return FUNC_SPARE;
    endfunction

    // Reuse known keys for hits; otherwise fresh keys, often at the ends of the range
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && used_keys.size() > 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        else if (r < 55)
            return KEY_W'($urandom_range(0, 15));
        else if (r < 62)
            return '1 - KEY_W'($urandom_range(0, 15));
        return $urandom;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return ALL_ONES;
        return {$urandom, $urandom};
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            put_request(pick_func(), pick_key(), pick_value());
    endtask

    initial
    begin
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= FUNC_FIND;
        req_ch.key   <= '0;
        req_ch.value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_nil_word(ALL_ONES);

        // Directed: empty table, front and back inserts, hits, rebinds, spare code
        put_request(FUNC_FIND,   32'h0000_0000, '0);
        put_request(FUNC_SPARE,  32'h0000_0000, ALL_ONES);
        put_request(FUNC_UPSERT, 32'h0000_0000, 64'h0);
        put_request(FUNC_INSERT, 32'h8000_0000, 64'h1234_5678_9ABC_DEF0);
        put_request(FUNC_UPSERT, 32'h0000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
        put_request(FUNC_UPSERT, 32'hFFFF_FFFF, ALL_ONES);
        put_request(FUNC_INSERT, 32'h0000_0000, 64'h5555_5555_5555_5555);
        put_request(FUNC_FIND,   32'hFFFF_FFFF, '0);
        put_request(FUNC_SPARE,  32'h8000_0000, '0);
        put_request(FUNC_SPARE,  32'h0000_1234, ALL_ONES);
        put_request(FUNC_FIND,   32'h0000_0007, '0);
        put_request(FUNC_INSERT, 32'h0000_0007, ALL_ONES);
        put_request(FUNC_UPSERT, 32'hFFFF_FFFE, 64'h5555_5555_5555_5555);
        put_request(FUNC_UPSERT, 32'h8000_0000, 64'hDEAD_BEEF_0000_0001);
        put_request(FUNC_INSERT, 32'h7FFF_FFFF, '0);
        put_request(FUNC_UPSERT, 32'h0000_0001, 64'h8000_0000_0000_0000);
        put_request(FUNC_FIND,   32'h0000_0001, '0);
        put_request(FUNC_FIND,   32'h7FFF_FFFF, '0);
        put_request(FUNC_UPSERT, 32'hFFFF_FFFF, '0);
        put_request(FUNC_FIND,   32'h0000_0000, '0);

        // Random blocks under different nil words; the table fills up during them
        set_nil_word('0);
        run_random(RANDOM_BLOCK);
        set_nil_word({$urandom, $urandom});
        run_random(RANDOM_BLOCK);
        set_nil_word(64'h8000_0000_0000_0001);
        run_random(RANDOM_BLOCK);

        drain_table();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d requests over %0d nil word settings in %0d cycles",
                 sent, nil_writes, cycle_count);
        $display("Responses: %0d existed, %0d inserted, %0d not found, %0d full; %0d errors",
                 n_existed, n_inserted, n_not_found, n_full, errors);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
